FILE: sv/hccq_pkg.sv
package hccq_pkg;

    localparam int MAX_W   = 31;   // max_value register width
    localparam int GRID_W  = 11;   // grid_size register width
    localparam int IDX_W   = 10;   // row / column index width
    localparam int COORD_W = 14;   // vertex coordinate width
    localparam int CH_W    = 8;    // colour channel width
    localparam int Q_BITS  = 16;   // fraction bits of value / max_value
    localparam int F_W     = 15;   // position inside one colour segment, 0..SEG_LEN

    localparam logic [F_W-1:0]     SEG_LEN    = 15'd16384;
    localparam logic [Q_BITS:0]    Q_ONE      = 17'h10000;
    localparam logic [CH_W-1:0]    CH_FULL    = 8'd255;
    localparam logic [CH_W-1:0]    CH_GREY    = 8'd238;
    localparam logic [COORD_W-1:0] CELL_PITCH = 14'd10;
    localparam logic [COORD_W-1:0] CELL_OFS   = 14'd1;
    localparam logic [COORD_W-1:0] QUAD_SIZE  = 14'd8;

    // Corner order of the two triangles, bit k belongs to vertex k
    localparam logic [5:0]         CORNER_DX  = 6'b011010;
    localparam logic [5:0]         CORNER_DY  = 6'b110100;
    localparam logic [2:0]         LAST_K     = 3'd5;

    typedef struct packed {
        logic [IDX_W-1:0]        cell_row;
        logic [IDX_W-1:0]        cell_col;
        logic signed [31:0]      cell_value;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] vertex_x;
        logic [COORD_W-1:0] vertex_y;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    alpha;
        logic               last_vertex;
    } t_out;

    // Data that rides along the divider stages
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               grey;
        logic               clamp;
    } t_side;

    // One finished cell: origin corner and colour
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
    } t_pix;

endpackage

FILE: sv/hccq_div.sv
module hccq_div
    import hccq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [MAX_W-1:0] i_mag,
    input  logic [MAX_W-1:0] i_div,
    input  t_side            i_side,
    output logic             o_vld,
    output logic [Q_BITS-1:0] o_quo,
    output t_side            o_side
);

    // One restoring step per stage; quotient bits enter from the right
    logic [MAX_W-1:0]  r_rem  [Q_BITS];
    logic [Q_BITS-1:0] r_quo  [Q_BITS];
    t_side             r_side [Q_BITS];
    logic [Q_BITS-1:0] r_vld;

    for (genvar s = 0; s < Q_BITS; s++) begin : g_step
        logic [MAX_W-1:0]  w_rem_in;
        logic [Q_BITS-1:0] w_quo_in;
        t_side             w_side_in;
        logic              w_vld_in;
        logic [MAX_W:0]    w_trial;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_mag;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
            assign w_vld_in  = i_vld;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_quo_in  = r_quo[s-1];
            assign w_side_in = r_side[s-1];
            assign w_vld_in  = r_vld[s-1];
        end

        assign w_trial = {w_rem_in, 1'b0};
        assign w_ge    = w_trial >= {1'b0, i_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? MAX_W'(w_trial - {1'b0, i_div}) : MAX_W'(w_trial);
                r_quo[s]  <= {w_quo_in[Q_BITS-2:0], w_ge};
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[Q_BITS-1];
    assign o_quo  = r_quo[Q_BITS-1];
    assign o_side = r_side[Q_BITS-1];

endmodule

FILE: sv/hccq_colour.sv
module hccq_colour
    import hccq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [Q_BITS-1:0] i_quo,
    input  t_side             i_side,
    output logic              o_vld,
    output t_pix              o_pix
);

    logic [Q_BITS:0]  w_ratio;
    logic [1:0]       w_seg;
    logic [F_W-1:0]   w_f;
    logic [F_W-1:0]   w_t;
    logic [F_W+6:0]   w_prod;
    logic [CH_W-1:0]  w_ramp;
    t_pix             w_pix;
    logic             r_vld;
    t_pix             r_pix;

    always_comb begin
        w_ratio = i_side.clamp ? Q_ONE : {1'b0, i_quo};
        // Full scale sits at the top end of the last segment
        if (w_ratio[Q_BITS]) begin
            w_seg = 2'd3;
            w_f   = SEG_LEN;
        end else begin
            w_seg = w_ratio[Q_BITS-1:Q_BITS-2];
            w_f   = {1'b0, w_ratio[Q_BITS-3:0]};
        end
        // Odd segments fall, even ones rise
        w_t    = w_seg[0] ? F_W'(SEG_LEN - w_f) : w_f;
        w_prod = (F_W+7)'({w_t, 8'b0} - {8'b0, w_t});
        w_ramp = w_prod[F_W+6:F_W-1];

        w_pix.x = i_side.x;
        w_pix.y = i_side.y;
        unique case (w_seg)
            2'd0: begin
                w_pix.red = '0;      w_pix.green = w_ramp;  w_pix.blue = CH_FULL;
            end
            2'd1: begin
                w_pix.red = '0;      w_pix.green = CH_FULL; w_pix.blue = w_ramp;
            end
            2'd2: begin
                w_pix.red = w_ramp;  w_pix.green = CH_FULL; w_pix.blue = '0;
            end
            default: begin
                w_pix.red = CH_FULL; w_pix.green = w_ramp;  w_pix.blue = '0;
            end
        endcase
        if (i_side.grey) begin
            w_pix.red   = CH_GREY;
            w_pix.green = CH_GREY;
            w_pix.blue  = CH_GREY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= w_pix;
        end
    end

    assign o_vld = r_vld;
    assign o_pix = r_pix;

endmodule

FILE: sv/hccq_vtx.sv
module hccq_vtx
    import hccq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_pix i_pix,
    output logic o_take,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic       r_have;
    logic [2:0] r_k;
    t_pix       r_pix;
    logic       r_out_vld;
    t_out       r_out;
    logic       w_load;
    logic       w_done;
    t_out       w_vtx;

    assign w_load = r_have && (!r_out_vld || i_out_ready);
    assign w_done = w_load && (r_k == LAST_K);
    assign o_take = !r_have || w_done;

    always_comb begin
        w_vtx.vertex_x    = r_pix.x + (CORNER_DX[r_k] ? QUAD_SIZE : '0);
        w_vtx.vertex_y    = r_pix.y + (CORNER_DY[r_k] ? QUAD_SIZE : '0);
        w_vtx.red         = r_pix.red;
        w_vtx.green       = r_pix.green;
        w_vtx.blue        = r_pix.blue;
        w_vtx.alpha       = CH_FULL;
        w_vtx.last_vertex = (r_k == LAST_K);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have    <= 1'b0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_have <= i_vld;
                r_k    <= '0;
            end else if (w_load) begin
                r_k    <= r_k + 3'd1;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_vld) begin
            r_pix <= i_pix;
        end
        if (w_load) begin
            r_out <= w_vtx;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

FILE: sv/heatmap_cell_quad_colour_unit.sv
// Heatmap cell quad generator with jet false colour. Each accepted cell inside the configured
// grid yields six vertices (two triangles of an 8x8 square at col*10+1, row*10+1), all with
// the same colour and alpha 255; cells outside the grid are dropped at the input. A cell
// accepted passes an input register, sixteen one-bit stages of the value/max_value divider,
// a colour stage, the vertex sequencer and the output register before its first vertex shows.
// Cells enter at one per cycle while the pipeline has room; sustained throughput is set by the
// single output register, which carries one vertex per cycle while i_out_ready is high, six
// per cell. The user must write max_value and grid_size over the APB port only while no cell
// is in flight; the block does not enforce this. pready is tied high.
module heatmap_cell_quad_colour_unit
    import hccq_pkg::*;
#(
    parameter int GRID_MAX = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LIM_W = $clog2(GRID_MAX + 1);
    localparam int CMP_W = (LIM_W > GRID_W) ? LIM_W : GRID_W;
    localparam logic REG_MAX_VALUE = 1'b0;
    localparam logic REG_GRID_SIZE = 1'b1;

    logic [MAX_W-1:0]  r_max_value;
    logic [GRID_W-1:0] r_grid_size;
    logic              w_reg_idx;
    logic              w_wr;

    logic [CMP_W-1:0]  w_grid;
    logic [CMP_W-1:0]  w_gmax;
    logic [CMP_W-1:0]  w_limit;
    logic              w_in_grid;
    logic              w_en;
    t_side             w_side;

    logic              r_s0_vld;
    logic [MAX_W-1:0]  r_s0_mag;
    t_side             r_s0_side;

    logic              w_div_vld;
    logic [Q_BITS-1:0] w_div_quo;
    t_side             w_div_side;
    logic              w_col_vld;
    t_pix              w_col_pix;
    logic              w_take;

    // Configuration registers
    assign w_reg_idx = paddr[2];
    assign w_wr      = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= '0;
            r_grid_size <= '0;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_MAX_VALUE: r_max_value <= pwdata[MAX_W-1:0];
                REG_GRID_SIZE: r_grid_size <= pwdata[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_MAX_VALUE: prdata = 32'(r_max_value);
            REG_GRID_SIZE: prdata = 32'(r_grid_size);
            default:       prdata = '0;
        endcase
    end

    // Input stage: grid check, coordinates and the grey / full-scale decisions
    assign w_grid    = CMP_W'(r_grid_size);
    assign w_gmax    = CMP_W'(GRID_MAX);
    assign w_limit   = (w_grid > w_gmax) ? w_gmax : w_grid;
    assign w_in_grid = (CMP_W'(i_in_data.cell_row) < w_limit)
                    && (CMP_W'(i_in_data.cell_col) < w_limit);

    always_comb begin
        w_side.x     = COORD_W'(i_in_data.cell_col) * CELL_PITCH + CELL_OFS;
        w_side.y     = COORD_W'(i_in_data.cell_row) * CELL_PITCH + CELL_OFS;
        w_side.grey  = i_in_data.cell_value[31] || (i_in_data.cell_value == '0)
                    || (r_max_value == '0);
        w_side.clamp = i_in_data.cell_value[MAX_W-1:0] >= r_max_value;
    end

    // Input, divider and colour stages advance unless the colour stage holds a cell the sequencer won't take
    assign w_en       = w_take || !w_col_vld;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in_valid && w_in_grid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_mag  <= i_in_data.cell_value[MAX_W-1:0];
            r_s0_side <= w_side;
        end
    end

    hccq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s0_vld),
        .i_mag   (r_s0_mag),
        .i_div   (r_max_value),
        .i_side  (r_s0_side),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    hccq_colour u_colour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_div_vld),
        .i_quo   (w_div_quo),
        .i_side  (w_div_side),
        .o_vld   (w_col_vld),
        .o_pix   (w_col_pix)
    );

    hccq_vtx u_vtx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_col_vld),
        .i_pix       (w_col_pix),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

    a_alpha_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.alpha == CH_FULL)
        else $error("alpha not full scale");

    a_jet_or_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.red == CH_FULL) || (o_out_data.green == CH_FULL)
            || (o_out_data.blue == CH_FULL)
            || ((o_out_data.red == CH_GREY) && (o_out_data.green == CH_GREY)
                && (o_out_data.blue == CH_GREY)))
        else $error("colour is neither on the jet map nor grey");

    a_quad_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_vertex |=> o_out_valid)
        else $error("gap inside the vertices of one cell");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

class quad_tracker;
    localparam int unsigned GRID_LIMIT = 1024;
    // bit k set: vertex k sits on the right / lower edge of the quad
    localparam bit [5:0] ON_RIGHT = 6'b011010;
    localparam bit [5:0] ON_LOWER = 6'b110100;

    hccq_pkg::t_out pending_vertices[$];
    // registers come out of reset at zero
    logic [30:0] max_value = '0;
    logic [10:0] grid_size = '0;
    int unsigned mismatches;
    int unsigned vertices_seen;
    int unsigned cells_drawn;
    int unsigned cells_dropped;
    int unsigned grey_cells;

    function void set_max(logic [31:0] wdata);
        max_value = wdata[30:0];
    endfunction

    function void set_grid(logic [31:0] wdata);
        grid_size = wdata[10:0];
    endfunction

    function int unsigned grid_in_use();
        return (grid_size > GRID_LIMIT) ? GRID_LIMIT : grid_size;
    endfunction

    function void jet_colour(logic [31:0] raw, output logic [7:0] r, output logic [7:0] g,
                             output logic [7:0] b);
        longint unsigned mag;
        longint unsigned ratio;
        int unsigned seg;
        int unsigned f;
        int unsigned up;
        int unsigned down;
        if (raw[31] || raw == 32'd0 || max_value == 31'd0) begin
            r = 8'd238;
            g = 8'd238;
            b = 8'd238;
            grey_cells++;
            return;
        end
        mag = raw[30:0];
        ratio = (mag << 16) / longint'(max_value);
        if (ratio > 65536) ratio = 65536;
        seg = ratio >> 14;
        // full scale stays in the last segment
        if (seg > 3) seg = 3;
        f = ratio - seg * 16384;
        up = (255 * f) >> 14;
        down = (255 * (16384 - f)) >> 14;
        case (seg)
            0: begin
                r = 8'd0; g = up[7:0]; b = 8'd255;
            end
            1: begin
                r = 8'd0; g = 8'd255; b = down[7:0];
            end
            2: begin
                r = up[7:0]; g = 8'd255; b = 8'd0;
            end
            default: begin
                r = 8'd255; g = down[7:0]; b = 8'd0;
            end
        endcase
    endfunction

    function void note_cell(hccq_pkg::t_in c);
        int unsigned lim;
        logic [13:0] x0;
        logic [13:0] y0;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        hccq_pkg::t_out v;
        lim = grid_in_use();
        if (c.cell_row >= lim || c.cell_col >= lim) begin
            cells_dropped++;
            return;
        end
        cells_drawn++;
        x0 = c.cell_col * 10 + 1;
        y0 = c.cell_row * 10 + 1;
        jet_colour(c.cell_value, r, g, b);
        for (int k = 0; k < 6; k++) begin
            v.vertex_x    = x0 + (ON_RIGHT[k] ? 14'd8 : 14'd0);
            v.vertex_y    = y0 + (ON_LOWER[k] ? 14'd8 : 14'd0);
            v.red         = r;
            v.green       = g;
            v.blue        = b;
            v.alpha       = 8'd255;
            v.last_vertex = (k == 5);
            pending_vertices.push_back(v);
        end
    endfunction

    task flag_mismatch(string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task compare_field(string field, int unsigned got, int unsigned want);
        if (got != want)
            flag_mismatch($sformatf("vertex %0d %s got %0d want %0d",
                                    vertices_seen, field, got, want));
    endtask

    task check_vertex(hccq_pkg::t_out got);
        hccq_pkg::t_out want;
        vertices_seen++;
        if (pending_vertices.size() == 0) begin
            flag_mismatch($sformatf("vertex %0d arrived with nothing pending (x %0d y %0d)",
                                    vertices_seen, got.vertex_x, got.vertex_y));
            return;
        end
        want = pending_vertices.pop_front();
        compare_field("vertex_x", got.vertex_x, want.vertex_x);
        compare_field("vertex_y", got.vertex_y, want.vertex_y);
        compare_field("red", got.red, want.red);
        compare_field("green", got.green, want.green);
        compare_field("blue", got.blue, want.blue);
        compare_field("alpha", got.alpha, want.alpha);
        compare_field("last_vertex", got.last_vertex, want.last_vertex);
    endtask
endclass

module tb;
    import hccq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned PHASE_CELLS  = 54;
    localparam logic [2:0]  ADDR_MAX_VALUE = 3'd0;
    localparam logic [2:0]  ADDR_GRID_SIZE = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    quad_tracker ledger;
    bit          running;
    int unsigned cycles;
    int unsigned cells_sent;
    int unsigned send_calm;
    int unsigned sink_calm;

    always #4 i_clk = ~i_clk;

    heatmap_cell_quad_colour_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always @(posedge i_clk) begin
        if (running) begin
            if (in_valid && in_ready) ledger.note_cell(in_data);
            if (out_valid && out_ready) ledger.check_vertex(out_data);
        end
    end

    // Occasionally fall into a stretch of back-to-back transactions
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    function automatic t_in make_cell(int unsigned row, int unsigned col, logic [31:0] value);
        t_in c;
        c.cell_row   = row[9:0];
        c.cell_col   = col[9:0];
        c.cell_value = value;
        return c;
    endfunction

    function automatic t_in random_cell();
        t_in c;
        int unsigned lim;
        longint unsigned m;
        longint unsigned top;
        lim = ledger.grid_in_use();
        m = ledger.max_value;
        if (lim > 0 && $urandom_range(0, 99) < 85) begin
            c.cell_row = $urandom_range(0, lim - 1);
            c.cell_col = $urandom_range(0, lim - 1);
        end else begin
            c.cell_row = $urandom;
            c.cell_col = $urandom;
        end
        top = m + m / 4;
        if (top > 64'h7FFF_FFFF) top = 64'h7FFF_FFFF;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c.cell_value = (m == 0) ? $urandom : $urandom_range(0, top);
            4, 5:       c.cell_value = $urandom;
            6:          c.cell_value = -$signed({1'b0, $urandom_range(1, 1000)});
            7:          c.cell_value = ($urandom_range(0, 4) * m) / 4;
            default:    c.cell_value = $urandom_range(0, 255);
        endcase
        return c;
    endfunction

    task automatic send_cell(t_in c);
        int unsigned gap;
        gap = draw_wait(send_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data  = c;
        in_valid = 1'b1;
        do @(posedge i_clk); while (!(in_valid && in_ready));
        cells_sent++;
    endtask

    // Hold the input off until every pending vertex is out
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (ledger.pending_vertices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (addr == ADDR_MAX_VALUE) ledger.set_max(data);
        else ledger.set_grid(data);
    endtask

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("heatmap_cell_quad_colour_unit regression: fail");
        $finish;
    end

    initial begin : vertex_sink
        int unsigned stall;
        wait (running);
        forever begin
            stall = draw_wait(sink_calm);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready = 1'b1;
            do @(posedge i_clk); while (!(out_valid && out_ready));
        end
    end

    initial begin : stimulus
        logic [31:0] probe_values [12];
        logic [31:0] max_word;
        int unsigned grid_word;
        ledger    = new();
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        probe_values = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 32'd16383, 32'd16384,
                         32'd32768, 32'd49152, 32'd65535, 32'd65536, 32'd65537,
                         32'h7FFF_FFFF};
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1'b1;

        // grid disabled out of reset
        send_cell(make_cell(0, 0, 32'd100));
        send_cell(make_cell(3, 7, -32'sd5));
        wait_idle();

        // zero maximum: grey everywhere, corners of the grid
        reg_write(ADDR_GRID_SIZE, 32'd1024);
        send_cell(make_cell(0, 0, 32'd500));
        send_cell(make_cell(1023, 1023, 32'd1));
        wait_idle();

        // segment boundaries, clamping and non-positive values
        reg_write(ADDR_MAX_VALUE, 32'd65536);
        foreach (probe_values[i])
            send_cell(make_cell(i * 93, 1023 - i * 77, probe_values[i]));
        wait_idle();

        // cells on and past the edge of a small grid
        reg_write(ADDR_GRID_SIZE, 32'd5);
        send_cell(make_cell(4, 4, 32'd40000));
        send_cell(make_cell(5, 0, 32'd40000));
        send_cell(make_cell(0, 5, 32'd40000));
        send_cell(make_cell(1023, 0, 32'd1));
        send_cell(make_cell(0, 1023, 32'd1));
        wait_idle();

        // oversized grid saturates, top bit of max is dropped
        reg_write(ADDR_GRID_SIZE, 32'hFFFF_FFFF);
        reg_write(ADDR_MAX_VALUE, 32'hFFFF_FFFF);
        send_cell(make_cell(1023, 1023, 32'h7FFF_FFFF));
        send_cell(make_cell(1023, 0, 32'd1));
        send_cell(make_cell(0, 1023, 32'h3FFF_FFFF));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin max_word = 32'd1000;      grid_word = 32; end
                1: begin max_word = 32'd65536;     grid_word = 1024; end
                2: begin max_word = 32'h7FFF_FFFF; grid_word = 2047; end
                3: begin max_word = $urandom;      grid_word = $urandom_range(1, 1024); end
                4: begin max_word = 32'd1;         grid_word = 3; end
                5: begin max_word = 32'd0;         grid_word = 100; end
                6: begin max_word = $urandom_range(1, 1 << 20); grid_word = 16; end
                default: begin
                    max_word  = $urandom;
                    grid_word = $urandom_range(1025, 2047);
                end
            endcase
            reg_write(ADDR_MAX_VALUE, max_word);
            reg_write(ADDR_GRID_SIZE, ($urandom & ~32'h7FF) | grid_word);
            for (int n = 0; n < PHASE_CELLS; n++) begin
                if (p == 2 && n == PHASE_CELLS / 2) wait_idle();
                send_cell(random_cell());
            end
            wait_idle();
        end

        $display("Sent %0d cells: %0d drawn, %0d outside the grid, %0d in grey.",
                 cells_sent, ledger.cells_drawn, ledger.cells_dropped, ledger.grey_cells);
        $display("Checked %0d vertices over 13 register settings, %0d mismatches.",
                 ledger.vertices_seen, ledger.mismatches);
        if (ledger.mismatches == 0) begin
            $display("heatmap_cell_quad_colour_unit regression: pass");
        end else begin
            $display("heatmap_cell_quad_colour_unit regression: fail");
        end
        $finish;
    end
endmodule
